FILE: design/beam_pair_direction_detector_top_macros.svh
// Assertion macros used by the beam pair direction detector controller
`ifndef BEAM_PAIR_DIRECTION_DETECTOR_TOP_MACROS_SVH
`define BEAM_PAIR_DIRECTION_DETECTOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define BPDD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define BPDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bpdd_pkg.sv
// Types and constants shared by the beam pair direction detector modules
package bpdd_pkg;

    localparam int DIST_W      = 16;
    localparam int ECHO_W      = 15;
    localparam int TRIG_W      = 9;
    localparam int PROD_W      = 32;
    localparam int RECIP_W     = 17;
    localparam int CM_SHIFT    = 22;
    localparam int QUOT_W      = PROD_W - CM_SHIFT;
    localparam int NUM_BEAMS   = 4;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    localparam logic [DIST_W-1:0]  NO_ECHO         = 16'hFFFF;
    localparam logic [ECHO_W-1:0]  ECHO_TIMEOUT_US = 15'd25000;
    // ceil(2^22 / 58): exact quotient for every 15-bit echo width
    localparam logic [RECIP_W-1:0] CM_RECIP        = 17'd72316;
    localparam logic [TRIG_W-1:0]  TRIG_RESET      = 9'd50;

    typedef enum logic [1:0] {
        DIR_QUIET    = 2'd0,
        DIR_APPROACH = 2'd1,
        DIR_LEAVE    = 2'd2,
        DIR_TIE      = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_DETECT  = 2'd1,
        EVT_CLEARED = 2'd2
    } evt_code_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic write;
        logic step;
        logic finish;
    } bpdd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
    } bpdd_status_t;

endpackage

FILE: design/bpdd_ctrl.sv
// Sequencing controller for the beam pair direction detector
`include "beam_pair_direction_detector_top_macros.svh"

module bpdd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  bpdd_pkg::bpdd_status_t status,
    output bpdd_pkg::bpdd_cmd_t    cmd
);
    import bpdd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;

    // Decode commands from the current state
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.write  = (state_reg == ST_WRITE);
    assign cmd.step   = (state_reg == ST_SCAN);
    assign cmd.finish = (state_reg == ST_FIN) && out_free;

    // Advance state and hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (status.scan_last)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Check sequencing
    `BPDD_ASSERT_NEXT(a_load_goes_write, cmd.load, state_reg == ST_WRITE,
        "accepted transaction did not move to write")
    `BPDD_ASSERT_NEXT(a_stall_holds_fin, (state_reg == ST_FIN) && !out_free,
        state_reg == ST_FIN && m_tvalid_reg, "blocked result left finish state")
    `BPDD_ASSERT_NEXT(a_scan_ends_fin, cmd.step && status.scan_last,
        state_reg == ST_FIN, "ring scan did not end in finish state")
    `BPDD_ASSERT_SAME(a_finish_slot_free, cmd.finish, !m_tvalid_reg || m_tready,
        "result register overwritten while still pending")

endmodule

FILE: design/bpdd_datapath.sv
// Datapath: distance conversion, beam state, history ring scan and result register
module bpdd_datapath #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bpdd_pkg::ECHO_W-1:0]       echo_time_us,
    input  logic                              cfg_wr_en,
    input  logic [bpdd_pkg::TRIG_W-1:0]       cfg_wr_data,
    input  bpdd_pkg::bpdd_cmd_t               cmd,
    output bpdd_pkg::bpdd_status_t            status,
    output logic [bpdd_pkg::OUT_DATA_W-1:0]   result_data
);
    import bpdd_pkg::*;

    localparam int HIST_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [HIST_W-1:0] LAST_POS = HIST_W'(HISTORY_DEPTH - 1);

    logic [TRIG_W-1:0]     trig_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  noecho_reg;
    logic [1:0]            slot_reg;
    logic [DIST_W-1:0]     dist_reg [NUM_BEAMS];
    logic [NUM_BEAMS-1:0]  hist_reg [HISTORY_DEPTH];
    logic [HIST_W-1:0]     hidx_reg;
    logic [HIST_W-1:0]     ptr_reg;
    logic [HIST_W-1:0]     pos_reg;
    logic [NUM_BEAMS-1:0]  prev_reg;
    logic [NUM_BEAMS-1:0]  found_reg;
    logic [HIST_W-1:0]     epos_reg [NUM_BEAMS];
    logic [NUM_BEAMS-1:0]  blocked_reg;
    logic                  was_appr_reg;
    logic [1:0]            meas_sensor_reg;
    logic [DIST_W-1:0]     meas_dist_reg;
    logic [OUT_DATA_W-1:0] result_reg;

    logic [DIST_W-1:0]     dist_new;
    logic [NUM_BEAMS-1:0]  blocked_new;
    logic [HIST_W-1:0]     hidx_next;
    logic [HIST_W-1:0]     ptr_next;
    logic [NUM_BEAMS-1:0]  entry;
    dir_t                  up_dir;
    dir_t                  dn_dir;
    logic                  approaching;
    logic                  dead;
    logic                  up_blk;
    logic                  dn_blk;
    evt_code_t             evt;

    // Convert the product to centimeters or the no-echo mark
    assign dist_new = noecho_reg ? NO_ECHO
                                 : {{(DIST_W-QUOT_W){1'b0}}, prod_reg[PROD_W-1:CM_SHIFT]};

    // Compare all beams with the new distance bypassed into its slot
    always_comb
    begin
        for (int k = 0; k < NUM_BEAMS; k++)
        begin
            if (slot_reg == 2'(k))
            begin
                blocked_new[k] = dist_new < {{(DIST_W-TRIG_W){1'b0}}, trig_reg};
            end
            else
            begin
                blocked_new[k] = dist_reg[k] < {{(DIST_W-TRIG_W){1'b0}}, trig_reg};
            end
        end
    end

    assign hidx_next = (hidx_reg == LAST_POS) ? '0 : hidx_reg + 1'b1;
    assign ptr_next  = (ptr_reg == LAST_POS) ? '0 : ptr_reg + 1'b1;
    assign entry     = hist_reg[ptr_reg];
    assign status.scan_last = (pos_reg == LAST_POS);

    // Resolve pair directions from the first rising edges
    always_comb
    begin
        if (found_reg[0] && found_reg[1])
        begin
            priority if (epos_reg[0] < epos_reg[1]) up_dir = DIR_APPROACH;
            else if (epos_reg[1] < epos_reg[0])     up_dir = DIR_LEAVE;
            else                                    up_dir = DIR_TIE;
        end
        else if (found_reg[0]) up_dir = DIR_APPROACH;
        else if (found_reg[1]) up_dir = DIR_LEAVE;
        else                   up_dir = DIR_QUIET;

        if (found_reg[2] && found_reg[3])
        begin
            priority if (epos_reg[2] < epos_reg[3]) dn_dir = DIR_APPROACH;
            else if (epos_reg[3] < epos_reg[2])     dn_dir = DIR_LEAVE;
            else                                    dn_dir = DIR_TIE;
        end
        else if (found_reg[2]) dn_dir = DIR_APPROACH;
        else if (found_reg[3]) dn_dir = DIR_LEAVE;
        else                   dn_dir = DIR_QUIET;
    end

    assign approaching = (up_dir == DIR_APPROACH) || (dn_dir == DIR_APPROACH);
    assign up_blk      = |blocked_reg[1:0];
    assign dn_blk      = |blocked_reg[3:2];
    assign dead        = (dist_reg[0] == NO_ECHO) && (dist_reg[1] == NO_ECHO) &&
                         (dist_reg[2] == NO_ECHO) && (dist_reg[3] == NO_ECHO);

    // Raise detect on a new approach, cleared once all beams are free
    always_comb
    begin
        priority if (approaching && !was_appr_reg)                  evt = EVT_DETECT;
        else if (!approaching && was_appr_reg && !up_blk && !dn_blk) evt = EVT_CLEARED;
        else                                                         evt = EVT_NONE;
    end

    // Hold the trigger register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg <= TRIG_RESET;
        end
        else if (cfg_wr_en)
        begin
            trig_reg <= cfg_wr_data;
        end
    end

    // Multiply by the reciprocal of 58 on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prod_reg   <= {{(PROD_W-ECHO_W){1'b0}}, echo_time_us} *
                          {{(PROD_W-RECIP_W){1'b0}}, CM_RECIP};
            noecho_reg <= (echo_time_us == '0) || (echo_time_us > ECHO_TIMEOUT_US);
        end
    end

    // Store beam state, the history ring and the approach flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            hidx_reg     <= '0;
            was_appr_reg <= 1'b0;
            for (int k = 0; k < NUM_BEAMS; k++)
            begin
                dist_reg[k] <= '0;
            end
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.write)
            begin
                dist_reg[slot_reg] <= dist_new;
                slot_reg           <= slot_reg + 2'd1;
                hist_reg[hidx_reg] <= blocked_new;
                hidx_reg           <= hidx_next;
            end
            if (cmd.finish)
            begin
                was_appr_reg <= approaching;
            end
        end
    end

    // Scan the ring oldest first, one entry per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            meas_sensor_reg <= slot_reg;
            meas_dist_reg   <= dist_new;
            blocked_reg     <= blocked_new;
            ptr_reg         <= hidx_next;
            pos_reg         <= '0;
            prev_reg        <= '0;
            found_reg       <= '0;
        end
        else if (cmd.step)
        begin
            for (int k = 0; k < NUM_BEAMS; k++)
            begin
                if (entry[k] && !prev_reg[k] && !found_reg[k])
                begin
                    found_reg[k] <= 1'b1;
                    epos_reg[k]  <= pos_reg;
                end
            end
            prev_reg <= entry;
            ptr_reg  <= ptr_next;
            pos_reg  <= pos_reg + 1'b1;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= {4'b0, meas_dist_reg, meas_sensor_reg, evt, dead, approaching,
                           dn_dir, up_dir, dn_blk, up_blk};
        end
    end

    assign result_data = result_reg;

endmodule

FILE: design/beam_pair_direction_detector_top.sv
// Top level of the beam pair direction detector
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[14:0] echo_time_us
// m_*       out  m_tvalid/m_tready  m_tdata: detector result, one per input transaction
// cfg_*     in   cfg_wr_en          cfg_wr_data[8:0] trigger_distance_cm
//
// Each item passes through its steps in order: the accepting edge registers the
// reciprocal product, then a write step for the distance and ring write, one scan
// step per ring entry for the edge scan, and a finish step to build the result.
// The ring scan sets the rate; the next item is taken the cycle after the result loads.
// Reset clears distances to 0 cm, the ring, the slot and ring write indexes, the approach flag and the trigger to 50.
// A stalled result holds in the output register; the block waits in its last step.
module beam_pair_direction_detector_top #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata[14:0] echo_time_us, [15] zero
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata[0] up pair blocked, [1] down pair blocked, [3:2] up pair direction,
    // [5:4] down pair direction, [6] approach flag, [7] all_sensors_dead,
    // [9:8] event_code, [11:10] measured_sensor, [27:12] measured_distance_cm,
    // [31:28] zero
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);
    import bpdd_pkg::*;

    bpdd_cmd_t    cmd;
    bpdd_status_t status;

    // Sequence each item through its steps
    bpdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Compute distances, ring scan and result
    bpdd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .echo_time_us (s_tdata[ECHO_W-1:0]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .status       (status),
        .result_data  (m_tdata)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the beam pair direction detector top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpdd_pkg::*;

    localparam int HIST          = 5;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = HIST + 8;
    localparam int US_PER_CM     = 58;
    localparam int MAX_CM        = 25000 / US_PER_CM;
    localparam int ECHO_MAX      = 32767;

    typedef enum int {
        PASS_APPROACH,
        PASS_LEAVE,
        PASS_SIDE_BY_SIDE,
        PASS_NONE
    } pass_kind_t;

    typedef struct {
        logic              up_blk;
        logic              dn_blk;
        dir_t              up_dir;
        dir_t              dn_dir;
        logic              approaching;
        logic              dead;
        evt_code_t         evt;
        logic [1:0]        sensor;
        logic [DIST_W-1:0] dist_cm;
    } verdict_t;

    // Predict each verdict from the echo stream and check the block against it
    class DirectionTracker;
        logic [TRIG_W-1:0] trigger;
        logic [1:0]        slot;
        logic [DIST_W-1:0] beam_cm [NUM_BEAMS];
        logic [3:0]        ring [HIST];
        int                ring_pos;
        bit                was_approaching;
        verdict_t          verdict_q[$];
        int                errors;
        int                checked;
        int                detects;
        int                clears;
        int                dead_seen;
        int                approach_seen;

        function new();
            trigger = TRIG_RESET;
            slot = '0;
            foreach (beam_cm[k]) beam_cm[k] = '0;
            foreach (ring[k]) ring[k] = '0;
            ring_pos = 0;
            was_approaching = 1'b0;
            errors = 0;
            checked = 0;
            detects = 0;
            clears = 0;
            dead_seen = 0;
            approach_seen = 0;
        endfunction

        // Position of the first unblocked-to-blocked edge, oldest entry first
        function int first_rise(int beam, int start);
            int pos;
            bit prev;
            bit cur;
            prev = 1'b0;
            pos = start;
            for (int i = 0; i < HIST; i++)
            begin
                cur = ring[pos][beam];
                if (cur && !prev)
                    return i;
                prev = cur;
                pos = (pos + 1) % HIST;
            end
            return -1;
        endfunction

        function dir_t pair_dir(int beam_a, int start);
            int a;
            int b;
            a = first_rise(beam_a, start);
            b = first_rise(beam_a + 1, start);
            if (a >= 0 && b >= 0)
            begin
                if (a < b)
                    return DIR_APPROACH;
                if (b < a)
                    return DIR_LEAVE;
                return DIR_TIE;
            end
            if (a >= 0)
                return DIR_APPROACH;
            if (b >= 0)
                return DIR_LEAVE;
            return DIR_QUIET;
        endfunction

        // Advance the model by one accepted echo transaction
        function void note_echo(logic [ECHO_W-1:0] echo);
            verdict_t          v;
            logic [3:0]        blocked;
            logic [DIST_W-1:0] cm;
            bit                now_app;
            if (echo == '0 || echo > ECHO_TIMEOUT_US)
                cm = NO_ECHO;
            else
                cm = DIST_W'(echo / US_PER_CM);
            beam_cm[slot] = cm;
            v.sensor = slot;
            v.dist_cm = cm;
            slot = slot + 2'd1;

            for (int k = 0; k < NUM_BEAMS; k++)
                blocked[k] = beam_cm[k] < DIST_W'(trigger);
            v.up_blk = |blocked[1:0];
            v.dn_blk = |blocked[3:2];

            ring[ring_pos] = blocked;
            ring_pos = (ring_pos + 1) % HIST;
            v.up_dir = pair_dir(0, ring_pos);
            v.dn_dir = pair_dir(2, ring_pos);
            now_app = (v.up_dir == DIR_APPROACH) || (v.dn_dir == DIR_APPROACH);

            v.dead = 1'b1;
            for (int k = 0; k < NUM_BEAMS; k++)
                if (beam_cm[k] != NO_ECHO)
                    v.dead = 1'b0;

            // A clear is dropped while any beam is blocked, yet the flag still follows
            if (now_app && !was_approaching)
                v.evt = EVT_DETECT;
            else if (!now_app && was_approaching && !v.up_blk && !v.dn_blk)
                v.evt = EVT_CLEARED;
            else
                v.evt = EVT_NONE;
            was_approaching = now_app;
            v.approaching = now_app;
            verdict_q.push_back(v);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transaction with the oldest pending verdict
        function void check_verdict(logic [OUT_DATA_W-1:0] d);
            verdict_t v;
            if (verdict_q.size() == 0)
            begin
                $error("result transaction %h arrived with no verdict pending", d);
                errors++;
                return;
            end
            v = verdict_q.pop_front();
            checked++;
            field_check("up_pair_block", v.up_blk, d[0]);
            field_check("down_pair_block", v.dn_blk, d[1]);
            field_check("up_pair_dir", v.up_dir, d[3:2]);
            field_check("down_pair_dir", v.dn_dir, d[5:4]);
            field_check("approach_flag", v.approaching, d[6]);
            field_check("all_sensors_dead", v.dead, d[7]);
            field_check("event_code", v.evt, d[9:8]);
            field_check("measured_sensor", v.sensor, d[11:10]);
            field_check("measured_distance_cm", v.dist_cm, d[27:12]);
            if (v.evt == EVT_DETECT)
                detects++;
            if (v.evt == EVT_CLEARED)
                clears++;
            if (v.dead)
                dead_seen++;
            if (v.approaching)
                approach_seen++;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [TRIG_W-1:0]     cfg_wr_data = '0;

    DirectionTracker tracker;
    int send_slot = 0;
    int items_sent = 0;
    int settings_used = 1;
    int cycle_count = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    // Extremes of the echo field, timeout edge, trigger edge and a pass through both pairs
    logic [ECHO_W-1:0] directed_echo [24] = '{
        15'd1,    15'd57,   15'd25000, 15'd25001,
        15'd0,    15'd32767, 15'd0,    15'd0,
        15'd2899, 15'd0,    15'd0,     15'd0,
        15'd2899, 15'd2899, 15'd0,     15'd0,
        15'd0,    15'd2899, 15'd2900,  15'd0,
        15'd0,    15'd0,    15'd0,     15'd58
    };

    beam_pair_direction_detector_top #(
        .HISTORY_DEPTH (HIST)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sample both channels at the rising edge; check results before noting inputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_verdict(m_tdata);
            if (s_tvalid && s_tready)
                tracker.note_echo(s_tdata[ECHO_W-1:0]);
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: stall a random number of cycles before each transaction
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = recv_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    // Offer one echo after a random gap and hold it until accepted
    task automatic send_echo(input logic [ECHO_W-1:0] echo);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, echo};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        send_slot = (send_slot + 1) % NUM_BEAMS;
        items_sent++;
    endtask

    // Hold the sender until every verdict is back, then let the block settle
    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        while (tracker.pending() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_trigger(input logic [TRIG_W-1:0] trig);
        wait_for_verdicts();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= trig;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.trigger = trig;
        settings_used++;
    endtask

    function automatic logic [ECHO_W-1:0] echo_for_cm(int cm);
        int e;
        e = cm * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
        if (e < 1)
            e = 1;
        if (e > 25000)
            e = 25000;
        return ECHO_W'(e);
    endfunction

    // Pick an echo that blocks or clears the beam under the current trigger
    function automatic logic [ECHO_W-1:0] pick_echo(bit blk);
        int trig;
        int hi;
        int cm;
        trig = tracker.trigger;
        if (blk && trig > 0)
        begin
            hi = (trig - 1 > MAX_CM) ? MAX_CM : trig - 1;
            if ($urandom_range(0, 1))
                cm = $urandom_range(0, hi);
            else
                cm = hi - $urandom_range(0, (hi < 3) ? hi : 3);
            return echo_for_cm(cm);
        end
        if (!blk && trig <= MAX_CM && $urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 1))
                cm = $urandom_range(trig, MAX_CM);
            else
                cm = trig + $urandom_range(0, 3);
            if (cm > MAX_CM)
                cm = MAX_CM;
            return echo_for_cm(cm);
        end
        if ($urandom_range(0, 1))
            return '0;
        return ECHO_W'($urandom_range(32'(ECHO_TIMEOUT_US) + 1, ECHO_MAX));
    endfunction

    // Drive a vessel passage: each pair sees A then B, B then A, both, or nothing
    task automatic run_pass(input int rounds);
        int start_a [2];
        int start_b [2];
        int len [2];
        int s;
        int beam;
        int pair;
        int r;
        bit blk;
        pass_kind_t kind;
        for (int p = 0; p < 2; p++)
        begin
            kind = pass_kind_t'($urandom_range(0, 3));
            s = $urandom_range(0, 3);
            len[p] = $urandom_range(1, 4);
            case (kind)
                PASS_APPROACH:
                begin
                    start_a[p] = s;
                    start_b[p] = s + $urandom_range(1, 2);
                end
                PASS_LEAVE:
                begin
                    start_b[p] = s;
                    start_a[p] = s + $urandom_range(1, 2);
                end
                PASS_SIDE_BY_SIDE:
                begin
                    start_a[p] = s;
                    start_b[p] = s;
                end
                default:
                begin
                    start_a[p] = rounds + 10;
                    start_b[p] = rounds + 10;
                end
            endcase
        end
        for (int n = 0; n < rounds * NUM_BEAMS; n++)
        begin
            beam = send_slot;
            pair = beam / 2;
            r = n / NUM_BEAMS;
            if (beam % 2 == 0)
                blk = (r >= start_a[pair]) && (r < start_a[pair] + len[pair]);
            else
                blk = (r >= start_b[pair]) && (r < start_b[pair] + len[pair]);
            // Occasional glitch on a single beam
            if ($urandom_range(0, 19) == 0)
                blk = !blk;
            send_echo(pick_echo(blk));
        end
    endtask

    // Mostly passages, some raw noise, now and then a full drain
    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
                run_pass($urandom_range(6, 12));
            else
                repeat ($urandom_range(4, 12)) send_echo(ECHO_W'($urandom_range(0, ECHO_MAX)));
            if ($urandom_range(0, 29) == 0)
                wait_for_verdicts();
        end
    endtask

    initial
    begin
        int trig_plan [7];
        int item_plan [7];
        tracker = new();
        trig_plan = '{0, 511, 1, 500, 0, 0, 50};
        item_plan = '{120, 200, 150, 200, 220, 220, 120};
        trig_plan[4] = $urandom_range(2, 499);
        trig_plan[5] = $urandom_range(2, 499);

        // Hold reset, release it away from the rising edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_echo[i])
        begin
            send_burst = ($urandom_range(0, 1) == 0);
            send_echo(directed_echo[i]);
        end
        run_random(176);

        foreach (trig_plan[i])
        begin
            write_trigger(TRIG_W'(trig_plan[i]));
            run_random(item_plan[i]);
        end

        wait_for_verdicts();
        $display("Checked %0d detector results over %0d trigger settings.",
                 tracker.checked, settings_used);
        $display("Saw %0d detect and %0d clear events, %0d approaching and %0d all-dead results.",
                 tracker.detects, tracker.clears, tracker.approach_seen, tracker.dead_seen);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
